// ----- design/crts_pkg.sv -----
package crts_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 9;
	localparam int CHAR_W      = 16;
	localparam int WORD_W      = 2 * CHAR_W;

	localparam int S_TDATA_W   = 56;
	localparam int M_TDATA_W   = 8;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	// input word kinds, carried in tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// register byte addresses
	localparam logic [PADDR_W-1:0] REG_ENTRIES_IN_USE = 3'd0;

	localparam logic [CNT_W-1:0] ENTRIES_RESET = 9'd1;

endpackage

// ----- design/crts_regs.sv -----
module crts_regs
	import crts_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready,
	output logic [CNT_W-1:0]         entries_in_use
);

	logic [CNT_W-1:0] entries_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == REG_ENTRIES_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (wr_en) begin
			entries_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_ENTRIES_IN_USE) begin
			prdata = {{(PDATA_W-CNT_W){1'b0}}, entries_q};
		end
	end

	assign entries_in_use = entries_q;

endmodule

// ----- design/char_range_table_search.sv -----
// Write word: table entry updated at the accept edge, no result.
// Query word: one probe of the range memory per cycle, up to 9 probes for a full
// table, through the single synchronous read port of the range memory (one dependent
// read per probe); no new word is taken until the answer is in the output register.
// Reset (arst_n low, asynchronous): control and result valid cleared, entries_in_use
// back to 1; the range memory keeps its contents and is undefined until written.
module char_range_table_search
	import crts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // entry_index, range_first, range_last, character
	input  logic [0:0]            s_tuser,  // command
	// master side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // found, zero fill
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_PROBE  = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   entries_in_use;

	// unpacked input word
	logic               command;
	logic [IDX_W-1:0]   entry_index;
	logic [CHAR_W-1:0]  range_first;
	logic [CHAR_W-1:0]  range_last;
	logic [CHAR_W-1:0]  character;

	// range memory
	logic [WORD_W-1:0]  range_mem [TABLE_DEPTH];
	logic [WORD_W-1:0]  rd_word_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               mem_wr;

	// search bounds: lo inclusive, hi exclusive
	logic [IDX_W-1:0]   lo_q, lo_d;
	logic [CNT_W-1:0]   hi_q, hi_d;
	logic [IDX_W-1:0]   mid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               res_q, res_d;

	logic               found_q, m_valid_q;
	logic               out_free;
	logic               s_acc;
	logic [CNT_W-1:0]   count;

	// probe evaluation
	logic               holds, at_lo, below;
	logic [IDX_W-1:0]   nxt_lo;
	logic [CNT_W-1:0]   nxt_hi;
	logic [CNT_W-1:0]   span;
	logic [CNT_W-1:0]   nxt_mid;

	crts_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.entries_in_use (entries_in_use)
	);

	assign command     = s_tuser[0];
	assign entry_index = s_tdata[7:0];
	assign range_first = s_tdata[23:8];
	assign range_last  = s_tdata[39:24];
	assign character   = s_tdata[55:40];

	// take a new word only between searches
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign mem_wr   = s_acc && (command == CMD_WRITE);
	assign out_free = !m_valid_q || m_tready;

	// clamp an oversized count to the table depth
	assign count = (entries_in_use > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
		: entries_in_use;

	// evaluate the word read for mid_q; compute the next probe in the same cycle
	assign holds  = (rd_word_q[CHAR_W-1:0] <= char_q) && (rd_word_q[WORD_W-1:CHAR_W] >= char_q);
	assign at_lo  = (mid_q == lo_q);
	assign below  = rd_word_q < {char_q, char_q};
	assign nxt_lo = below ? mid_q : lo_q;
	assign nxt_hi = below ? hi_q : {1'b0, mid_q};
	assign span   = nxt_hi - {1'b0, nxt_lo};
	assign nxt_mid = {1'b0, nxt_lo} + (span >> 1);

	// first probe lands on count/2; later probes follow the narrowed interval
	always_comb begin
		if (state_q == ST_PROBE) begin
			rd_addr = nxt_mid[IDX_W-1:0];
		end else begin
			rd_addr = count[CNT_W-1:1];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			range_mem[entry_index] <= {range_last, range_first};
		end
		rd_word_q <= range_mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		res_d   = res_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc && (command == CMD_QUERY)) begin
					lo_d = '0;
					hi_d = count;
					if (count == '0) begin
						// empty table: no probe, answer not found
						res_d   = 1'b0;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				if (holds || at_lo) begin
					res_d   = holds;
					state_d = out_free ? ST_IDLE : ST_FINISH;
				end else begin
					lo_d = nxt_lo;
					hi_d = nxt_hi;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// search payload: bounds load when a query is taken and advance with each probe; mid_q follows the read address
	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		res_q <= res_d;
		mid_q <= rd_addr;
		if (s_acc) begin
			char_q <= character;
		end
	end

	// output register: load the answer when the slot is free, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_PROBE) && (holds || at_lo) && out_free) begin
			m_valid_q <= 1'b1;
		end else if ((state_q == ST_FINISH) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_PROBE) && (holds || at_lo) && out_free) begin
			found_q <= holds;
		end else if ((state_q == ST_FINISH) && out_free) begin
			found_q <= res_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, found_q};

`ifndef SYNTHESIS
	// the probe always lies inside the live interval
	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (({1'b0, mid_q} < hi_q) && (mid_q >= lo_q)))
		else $error("probe index outside search interval");

	// the interval never collapses while probing
	a_interval_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (hi_q > {1'b0, lo_q}))
		else $error("empty search interval during probe");

	// a query leaves idle on the next cycle
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (command == CMD_QUERY)) |=> (state_q != ST_IDLE))
		else $error("query accepted but search not started");

	// a pending answer never overwrites an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && m_valid_q && !m_tready) |=> (state_q == ST_FINISH))
		else $error("result dropped while output stalled");
`endif

endmodule

// ----- test/range_search_checker.sv -----
module range_search_checker
	import crts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // entry_index, range_first, range_last, character
	input  logic [0:0]           s_tuser,  // command
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,  // found, zero fill
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	input  logic [PDATA_W-1:0]   prdata,
	input  logic                 pready,
	output int                   fail_count,
	output int                   pending,
	output int                   writes_seen,
	output int                   queries_seen,
	output int                   hits_seen
);

	logic [WORD_W-1:0] range_mirror [TABLE_DEPTH];
	logic [CNT_W-1:0]  count_mirror;
	bit                found_due [$];
	int                misses;
	int                nwrites;
	int                nqueries;
	int                nhits;

	// binary search over the mirrored table, low bound inclusive, high bound exclusive
	function automatic bit range_lookup(input logic [CHAR_W-1:0] ch);
		int                span;
		int                lo;
		int                hi;
		int                mid;
		bit                hit;
		bit                done;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] w;
		span = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
		key  = {ch, ch};
		lo   = 0;
		hi   = span;
		hit  = 1'b0;
		done = (span == 0);
		while (!done) begin
			mid = lo + (hi - lo) / 2;
			w   = range_mirror[mid];
			if (w[CHAR_W-1:0] <= ch && w[WORD_W-1:CHAR_W] >= ch) begin
				hit  = 1'b1;
				done = 1'b1;
			end else if (mid == lo) begin
				done = 1'b1;
			end else if (w < key) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return hit;
	endfunction

	task automatic note_miss(input string what, input int want, input int got);
		misses++;
		if (misses <= 10)
			$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : observe
		bit want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				range_mirror[i] = '0;
			count_mirror = ENTRIES_RESET;
			found_due.delete();
			misses   = 0;
			nwrites  = 0;
			nqueries = 0;
			nhits    = 0;
		end else begin
			if (psel && penable && pready && paddr == REG_ENTRIES_IN_USE) begin
				if (pwrite)
					count_mirror = pwdata[CNT_W-1:0];
				else if (prdata !== PDATA_W'(count_mirror))
					note_miss("entries_in_use readback", count_mirror, prdata);
			end
			// retire results before taking new searches
			if (m_tvalid && m_tready) begin
				if (found_due.size() == 0) begin
					note_miss("result with no search outstanding (expected -1)", -1, m_tdata[0]);
				end else begin
					want = found_due.pop_front();
					if (m_tdata[0] !== want)
						note_miss("found", want, m_tdata[0]);
					if (m_tdata[0] === 1'b1)
						nhits++;
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == CMD_WRITE) begin
					range_mirror[s_tdata[IDX_W-1:0]] = s_tdata[IDX_W +: WORD_W];
					nwrites++;
				end else begin
					found_due.push_back(range_lookup(s_tdata[IDX_W+WORD_W +: CHAR_W]));
					nqueries++;
				end
			end
		end
		fail_count   <= misses;
		pending      <= found_due.size();
		writes_seen  <= nwrites;
		queries_seen <= nqueries;
		hits_seen    <= nhits;
	end

endmodule

// ----- test/tb.sv -----
module tb;
	import crts_pkg::*;

	// length of the one long result-side hold-off
	localparam int HOLD_CYCLES = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;  // entry_index, range_first, range_last, character
	logic [0:0]           s_tuser;  // command
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;  // found, zero fill
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	int fail_count;
	int pending;
	int writes_seen;
	int queries_seen;
	int hits_seen;

	// stimulus-side copy of the ranges, used only to aim searches at edges
	logic [CHAR_W-1:0] first_of [TABLE_DEPTH];
	logic [CHAR_W-1:0] last_of  [TABLE_DEPTH];

	int burst_left;
	int words_sent;
	int sizes_run;
	bit hold_go;
	bit hold_done;

	char_range_table_search uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	range_search_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending      (pending),
		.writes_seen  (writes_seen),
		.queries_seen (queries_seen),
		.hits_seen    (hits_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one word on the input side. Called at a rising edge; returns at the
	// edge where the word was taken. Between bursts, drop valid for a random gap;
	// a zero gap keeps valid high straight into the next burst.
	task automatic put_word(input logic cmd, input logic [IDX_W-1:0] idx,
				input logic [CHAR_W-1:0] first, input logic [CHAR_W-1:0] last,
				input logic [CHAR_W-1:0] ch);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {ch, last, first, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		words_sent++;
		if (cmd == CMD_WRITE) begin
			first_of[idx] = first;
			last_of[idx]  = last;
		end
	endtask

	// Drain the block, give it time to finish any write in flight, then program
	// entries_in_use and read it back over the register port.
	task automatic settle_and_set(input int count);
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= REG_ENTRIES_IN_USE;
		pwdata  <= PDATA_W'(count);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// back-to-back read of the same register
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sizes_run++;
	endtask

	// Fill entries 0..n-1. A sorted fill spreads non-overlapping ranges over
	// the code space, with the outer ends pushed to 0 and 0xFFFF now and then;
	// an unsorted fill is raw random words, inverted ranges included.
	task automatic load_table(input int n, input bit sorted);
		int                w;
		logic [CHAR_W-1:0] f;
		logic [CHAR_W-1:0] l;
		w = 65536 / n;
		for (int i = 0; i < n; i++) begin
			if (sorted) begin
				f = CHAR_W'(i * w + $urandom_range(0, w / 2));
				l = CHAR_W'(f + $urandom_range(0, w / 2 - 1));
				if (i == 0 && $urandom_range(0, 1))
					f = '0;
				if (i == n - 1 && $urandom_range(0, 1))
					l = '1;
				if ($urandom_range(0, 7) == 0)
					l = f;
			end else begin
				f = CHAR_W'($urandom);
				l = CHAR_W'($urandom);
			end
			put_word(CMD_WRITE, IDX_W'(i), f, l, CHAR_W'($urandom));
		end
		// stray writes past the searched part must not disturb the search
		if (n < TABLE_DEPTH)
			repeat ($urandom_range(0, 3))
				put_word(CMD_WRITE, IDX_W'($urandom_range(n, TABLE_DEPTH - 1)),
					 CHAR_W'($urandom), CHAR_W'($urandom), CHAR_W'($urandom));
	endtask

	// Aim a search at range edges, just outside them, inside, or anywhere.
	function automatic logic [CHAR_W-1:0] pick_char(input int n);
		int j;
		if (n == 0)
			return CHAR_W'($urandom);
		j = $urandom_range(0, n - 1);
		case ($urandom_range(0, 6))
		0: return first_of[j];
		1: return last_of[j];
		2: return first_of[j] - 1'b1;
		3: return last_of[j] + 1'b1;
		4: return (first_of[j] <= last_of[j]) ?
			  CHAR_W'($urandom_range(last_of[j], first_of[j])) : first_of[j];
		5: return $urandom_range(0, 1) ? '1 : '0;
		default: return CHAR_W'($urandom);
		endcase
	endfunction

	// Result side: stretches of always-ready, coin-flip, mostly-stalled and
	// toggling, plus one long hold-off once the sender is told to push through it.
	initial begin : receiver
		int mode;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_go && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(8, 60)) begin
				case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ~m_tready;
				endcase
				@(posedge clk);
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int count;
		int n;
		int queries;
		int rand_start;
		burst_left = 0;
		words_sent = 0;
		sizes_run  = 0;
		hold_go    = 1'b0;
		hold_done  = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_WRITE;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. After reset one entry is searched: make it cover
		// everything and hit both ends of the code space. Unused fields are
		// all ones or all zeros to flip every bit.
		put_word(CMD_WRITE, '0, 16'h0000, 16'hFFFF, '1);
		put_word(CMD_QUERY, '1, '1, '1, 16'h0000);
		put_word(CMD_QUERY, '0, '0, '0, 16'hFFFF);

		// empty table: no probe, never found
		settle_and_set(0);
		put_word(CMD_QUERY, '0, '0, '0, 16'h1234);

		// three sorted ranges: low, a single character, top of the space
		settle_and_set(3);
		put_word(CMD_WRITE, 8'd0, 16'h0010, 16'h0020, '0);
		put_word(CMD_WRITE, 8'd1, 16'h0100, 16'h0100, '1);
		put_word(CMD_WRITE, 8'd2, 16'hFF00, 16'hFFFF, '0);
		put_word(CMD_QUERY, '0, '0, '0, 16'h0010);
		put_word(CMD_QUERY, '0, '0, '0, 16'h0020);
		put_word(CMD_QUERY, '0, '0, '0, 16'h000F);
		put_word(CMD_QUERY, '0, '0, '0, 16'h0021);
		put_word(CMD_QUERY, '0, '0, '0, 16'h0100);
		put_word(CMD_QUERY, '0, '0, '0, 16'h00FF);
		put_word(CMD_QUERY, '0, '0, '0, 16'h0101);
		put_word(CMD_QUERY, '0, '0, '0, 16'hFFFF);
		put_word(CMD_QUERY, '0, '0, '0, 16'h0000);
		put_word(CMD_QUERY, '0, '0, '0, 16'h8000);

		// break the ordering with an inverted range in the middle
		put_word(CMD_WRITE, 8'd1, 16'h8000, 16'h7FFF, '1);
		put_word(CMD_QUERY, '0, '0, '0, 16'h0100);
		put_word(CMD_QUERY, '0, '0, '0, 16'h8000);
		put_word(CMD_QUERY, '0, '0, '0, 16'h7FFF);

		// Random part, one table size per phase. Phase 1 fills the whole table
		// and holds the result side off; phases 2 and 3 search past the depth
		// on that full table; phase 4 searches an empty table. The rest use
		// small tables, mostly sorted, some raw.
		rand_start = words_sent;
		for (int p = 0; words_sent - rand_start < 600 || p < 8; p++) begin
			case (p)
			1: count = TABLE_DEPTH;
			2: count = 511;
			3: count = $urandom_range(TABLE_DEPTH + 1, 510);
			4: count = 0;
			default: count = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 64) :
							     $urandom_range(1, 16);
			endcase
			settle_and_set(count);
			n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
			if (p < 2 || p > 4)
				load_table(n, p == 1 || $urandom_range(0, 5) != 0);
			queries = (p == 1) ? 40 : $urandom_range(15, 30);
			// keep searches coming while the result side is blocked
			if (p == 1)
				hold_go = 1'b1;
			repeat (queries) begin
				if ($urandom_range(0, 9) == 0)
					put_word(CMD_WRITE, IDX_W'($urandom), CHAR_W'($urandom),
						 CHAR_W'($urandom), CHAR_W'($urandom));
				else
					put_word(CMD_QUERY, IDX_W'($urandom), CHAR_W'($urandom),
						 CHAR_W'($urandom), pick_char(n));
			end
		end

		// drain and let any late result show up
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d table writes and %0d searches (%0d found) over %0d entry counts,",
			 writes_seen, queries_seen, hits_seen, sizes_run);
		$display("from empty through full and oversized; result side held off %0d cycles once.",
			 HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
